>>> design/pjq_pkg.sv
// Package for the priority job queue: widths, codes, cell types.
`timescale 1ns / 1ps
`default_nettype none
package pjq_pkg;

  localparam int unsigned IdW      = 32;
  localparam int unsigned PrioW    = 8;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned OccW     = 5;
  localparam int unsigned OpW      = 2;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned PrioBitsDef   = 8;

  // Op codes; the high bit set means dispatch (both 2 and 3).
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_CANCEL = 2'd1;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED   = 3'd0,
    ST_FULL       = 3'd1,
    ST_CANCELLED  = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_DISPATCHED = 3'd4,
    ST_DROPPED    = 3'd5,
    ST_EMPTY      = 3'd6
  } status_e;

  // One queue slot.
  typedef struct packed {
    logic             valid;
    logic             cancelled;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic             ins;
    logic             cnc;
    logic             dsp;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } cmd_t;

  localparam entry_t EntryEmpty = '{valid: 1'b0, cancelled: 1'b0, id: '0, prio: '0};

endpackage
`default_nettype wire

>>> design/pjq_cell.sv
// One slot of the sorted queue: holds an entry, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module pjq_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pjq_pkg::cmd_t   cmd_i,
  input  wire pjq_pkg::entry_t left_i,       // entry of the slot in front
  input  wire logic            left_cond_i,  // slot in front takes the new item or shifts
  input  wire pjq_pkg::entry_t right_i,      // entry of the slot behind
  input  wire logic            found_i,      // an earlier slot matched the cancel id
  output pjq_pkg::entry_t      entry_o,
  output logic                 cond_o,
  output logic                 found_o
);
  import pjq_pkg::*;

  entry_t entry_q, entry_d;
  logic   match;

  // Queue is sorted, so this is true from the insert point to the tail.
  assign cond_o  = !entry_q.valid || (cmd_i.prio > entry_q.prio);
  assign match   = entry_q.valid && (entry_q.id == cmd_i.id);
  assign found_o = found_i || match;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (left_cond_i) begin
        entry_d = left_i;
      end else if (cond_o) begin
        entry_d.valid     = 1'b1;
        entry_d.cancelled = 1'b0;
        entry_d.id        = cmd_i.id;
        entry_d.prio      = cmd_i.prio;
      end
    end else if (cmd_i.cnc) begin
      if (match && !found_i) begin
        entry_d.cancelled = 1'b1;
      end
    end else if (cmd_i.dsp) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= EntryEmpty;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule
`default_nettype wire

>>> design/priority_job_queue_with_cancel.sv
// Top level: priority-sorted job queue with cancel, built as a row of slot cells.
// Result: the result of an item accepted at edge N shows with done_o for the cycle
//   after edge N, for exactly one cycle.
// Throughput: one item per cycle; every slot cell compares and shifts in parallel.
// Reset: asynchronous, active low; queue empties, no result is shown.
// busy stays low: the receiver cannot stall, so nothing holds items off.
`timescale 1ns / 1ps
`default_nettype none
module priority_job_queue_with_cancel #(
  parameter int unsigned QUEUE_DEPTH   = pjq_pkg::QueueDepthDef,
  parameter int unsigned PRIORITY_BITS = pjq_pkg::PrioBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [pjq_pkg::OpW-1:0]     op_i,
  input  wire logic [pjq_pkg::IdW-1:0]     job_id_i,
  input  wire logic [pjq_pkg::PrioW-1:0]   job_priority_i,
  output logic                             done_o,
  output logic [pjq_pkg::StatusW-1:0]      status_o,
  output logic [pjq_pkg::IdW-1:0]          out_job_id_o,
  output logic [pjq_pkg::PrioW-1:0]        out_priority_o,
  output logic [pjq_pkg::OccW-1:0]         occupancy_o
);
  import pjq_pkg::*;

  localparam int unsigned CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MaskBits = (PRIORITY_BITS < PrioW) ? PRIORITY_BITS : PrioW;
  localparam logic [PrioW-1:0] PrioMask = PrioW'((64'd1 << MaskBits) - 64'd1);

  // Cell row state
  entry_t                 cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_cond;
  logic [QUEUE_DEPTH:0]   found_chain;  // ripple of "already matched" front to back

  logic                   accept;
  logic                   is_cancel, is_dispatch, is_insert;
  logic                   full, empty;
  cmd_t                   cmd;

  logic [CntW-1:0]        count_q, count_d;
  logic                   done_q;
  status_e                status_q, status_d;
  logic [IdW-1:0]         out_id_q, out_id_d;
  logic [PrioW-1:0]       out_prio_q, out_prio_d;
  logic [OccW-1:0]        occ_q, occ_d;
  logic [CntW+OccW-1:0]   occ_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_cancel   = (op_i == OP_CANCEL);
  assign is_insert   = (op_i == OP_INSERT);
  assign is_dispatch = !is_insert && !is_cancel;  // high op bit

  // Valid bits form a thermometer: last slot valid means full, first means non-empty.
  assign full  = cell_entry[QUEUE_DEPTH-1].valid;
  assign empty = !cell_entry[0].valid;

  always_comb begin
    cmd.ins  = accept && is_insert && !full;
    cmd.cnc  = accept && is_cancel;
    cmd.dsp  = accept && is_dispatch && !empty;
    cmd.id   = job_id_i;
    cmd.prio = job_priority_i & PrioMask;
  end

  assign found_chain[0] = 1'b0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_c;

    if (g == 0) begin : g_front
      assign left_e = EntryEmpty;
      assign left_c = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[g-1];
      assign left_c = cell_cond[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = EntryEmpty;  // tail slot frees up on dispatch
    end else begin : g_body
      assign right_e = cell_entry[g+1];
    end

    pjq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left_e),
      .left_cond_i (left_c),
      .right_i     (right_e),
      .found_i     (found_chain[g]),
      .entry_o     (cell_entry[g]),
      .cond_o      (cell_cond[g]),
      .found_o     (found_chain[g+1])
    );
  end

  // Occupancy and result
  always_comb begin
    count_d    = count_q;
    status_d   = ST_INSERTED;
    out_id_d   = '0;
    out_prio_d = '0;
    if (is_insert) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_INSERTED;
        count_d  = count_q + CntW'(1);
      end
    end else if (is_cancel) begin
      status_d = found_chain[QUEUE_DEPTH] ? ST_CANCELLED : ST_NOT_FOUND;
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d = count_q - CntW'(1);
        if (cell_entry[0].cancelled) begin
          status_d = ST_DROPPED;  // removed silently, fields stay zero
        end else begin
          status_d   = ST_DISPATCHED;
          out_id_d   = cell_entry[0].id;
          out_prio_d = cell_entry[0].prio;
        end
      end
    end
    if (!accept) begin
      count_d = count_q;
    end
  end

  assign occ_ext = {{OccW{1'b0}}, count_d};
  assign occ_d   = occ_ext[OccW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      out_id_q   <= out_id_d;
      out_prio_q <= out_prio_d;
      occ_q      <= occ_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_job_id_o   = out_id_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = occ_q;

endmodule
`default_nettype wire

>>> design/pjq_port_checker.sv
// Port-level checks for the priority job queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pjq_port_checker #(
  parameter int unsigned QUEUE_DEPTH = pjq_pkg::QueueDepthDef
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic [pjq_pkg::StatusW-1:0] status_o,
  input wire logic [pjq_pkg::IdW-1:0]     out_job_id_o,
  input wire logic [pjq_pkg::PrioW-1:0]   out_priority_o,
  input wire logic [pjq_pkg::OccW-1:0]    occupancy_o
);
  import pjq_pkg::*;

  localparam logic [OccW-1:0] DepthOcc = OccW'(QUEUE_DEPTH);

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted item gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without an accepted item");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DISPATCHED) |-> (out_job_id_o == '0 && out_priority_o == '0))
    else $error("id or priority nonzero on a non-dispatch result");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (occupancy_o == DepthOcc))
    else $error("full reported below depth");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (occupancy_o == '0))
    else $error("empty reported with entries held");

endmodule

bind priority_job_queue_with_cancel pjq_port_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pjq_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .status_o       (status_o),
  .out_job_id_o   (out_job_id_o),
  .out_priority_o (out_priority_o),
  .occupancy_o    (occupancy_o)
);
`default_nettype wire
